// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge outside reset.
`define DDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define DDA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define DDA_ASSERT(lbl, prop, msg)
`define DDA_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== design/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Widths, item and command types, and state codes shared by all modules.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 16;
  localparam int ACC_BITS      = COORD_BITS + FRAC_BITS;
  localparam int INC_BITS      = FRAC_BITS + 2;
  localparam int LEFT_BITS     = COORD_BITS + 1;
  localparam int REM_BITS      = COORD_BITS + 1;
  localparam int QUO_BITS      = FRAC_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(QUO_BITS);

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } pixel_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic                  is_start;
    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_BITS-1:0] mag_x;
    logic [COORD_BITS-1:0] mag_y;
    logic [COORD_BITS-1:0] step;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
  } cmd_t;

  typedef enum logic {
    BACK_RUN    = 1'b0,
    BACK_DIVIDE = 1'b1
  } back_state_t;

endpackage

// ===== design/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Digital differential analyzer line generator with a queued command path.
// ----------------------------------------------------------------------------
// A start transaction (func = 0) loads two endpoints; each tick transaction
// (func = 1) then yields one pixel, the first endpoint included and the far
// endpoint excluded, with last_pixel set on the final one. A line has
// max(|dx|, |dy|) pixels; equal endpoints give none, and a tick with no line
// in progress gives nothing. Ticks run at one pixel per clock once the back
// end is streaming and pixel_stall is low; a tick's pixel shows on the
// output the cycle after it is taken. A start with distinct endpoints holds
// the back end while it loads the line and runs the shared radix-2 divider
// that forms both Q1.16 increments; during that time the front end keeps
// taking transactions into the QUEUE_DEPTH-entry command queue, and input
// stall rises only when that queue is full. The output register holds the
// current pixel steady under pixel_stall; further ticks wait in the queue
// until it is taken.
// ----------------------------------------------------------------------------
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  output logic   pixel_valid,
  input  logic   pixel_stall,
  output pixel_t pixel
);

  // Classified commands between front and back ends.
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic cmd_push;
  logic queue_full;
  logic head_valid;
  logic cmd_pop;

  // Classify: start or tick, deltas, direction, step count.
  dda_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  // Hold commands while the back end divides or the output stalls.
  dda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .full     (queue_full),
    .pop      (cmd_pop),
    .valid    (head_valid),
    .head     (head_cmd)
  );

  // Set up increments, advance accumulators, present pixels.
  dda_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (head_valid),
    .cmd         (head_cmd),
    .cmd_pop     (cmd_pop),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .pixel_stall (pixel_stall)
  );

endmodule

// ===== design/dda_front.sv =====
// ----------------------------------------------------------------------------
// DDA front end
// Accepts input transactions and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module dda_front import dda_pkg::*; (
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  queue_full,
  output logic  cmd_push,
  output cmd_t  cmd
);

  logic                  neg_x;
  logic                  neg_y;
  logic [COORD_BITS-1:0] mag_x;
  logic [COORD_BITS-1:0] mag_y;

  assign item_stall = queue_full;
  assign cmd_push   = item_valid && !queue_full;

  // Take endpoint deltas apart into magnitude and direction.
  always_comb begin
    neg_x = item.end_x < item.start_x;
    neg_y = item.end_y < item.start_y;
    mag_x = neg_x ? item.start_x - item.end_x : item.end_x - item.start_x;
    mag_y = neg_y ? item.start_y - item.end_y : item.end_y - item.start_y;
  end

  always_comb begin
    cmd.is_start = (item.func == FUNC_START);
    cmd.neg_x    = neg_x;
    cmd.neg_y    = neg_y;
    cmd.mag_x    = mag_x;
    cmd.mag_y    = mag_y;
    cmd.step     = (mag_x > mag_y) ? mag_x : mag_y;
    cmd.start_x  = item.start_x;
    cmd.start_y  = item.start_y;
  end

endmodule

// ===== design/dda_queue.sv =====
// ----------------------------------------------------------------------------
// DDA command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module dda_queue import dda_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cmd_t                entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = (count == CNT_BITS'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/dda_back.sv =====
// ----------------------------------------------------------------------------
// DDA back end
// Sets up lines with a radix-2 divider and steps the accumulators per tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_back import dda_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_pop,
  output logic   pixel_valid,
  output pixel_t pixel,
  input  logic   pixel_stall
);

  back_state_t             state;
  back_state_t             state_next;
  logic [ACC_BITS-1:0]     acc_x;
  logic [ACC_BITS-1:0]     acc_y;
  logic [INC_BITS-1:0]     inc_x;
  logic [INC_BITS-1:0]     inc_y;
  logic [LEFT_BITS-1:0]    pixels_left;
  logic                    line_active;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [REM_BITS-1:0]     rem_x;
  logic [REM_BITS-1:0]     rem_y;
  logic [QUO_BITS-1:0]     quo_x;
  logic [QUO_BITS-1:0]     quo_y;
  logic [COORD_BITS-1:0]   divisor;
  logic                    neg_x;
  logic                    neg_y;

  logic                    out_free;
  logic                    emit;
  logic                    load_div;
  logic                    div_last;
  logic                    last_one;
  logic [REM_BITS-1:0]     div_ext;
  logic                    ge_x;
  logic                    ge_y;
  logic [REM_BITS-1:0]     sub_x;
  logic [REM_BITS-1:0]     sub_y;
  logic [QUO_BITS-1:0]     quo_x_next;
  logic [QUO_BITS-1:0]     quo_y_next;
  logic [INC_BITS-1:0]     qx_ext;
  logic [INC_BITS-1:0]     qy_ext;

  // One restoring division step for both axes against the shared divisor.
  always_comb begin
    div_ext    = {1'b0, divisor};
    ge_x       = rem_x >= div_ext;
    ge_y       = rem_y >= div_ext;
    sub_x      = ge_x ? rem_x - div_ext : rem_x;
    sub_y      = ge_y ? rem_y - div_ext : rem_y;
    quo_x_next = {quo_x[QUO_BITS-2:0], ge_x};
    quo_y_next = {quo_y[QUO_BITS-2:0], ge_y};
    qx_ext     = {1'b0, quo_x_next};
    qy_ext     = {1'b0, quo_y_next};
    div_last   = (div_cnt == DIV_CNT_BITS'(QUO_BITS - 1));
    last_one   = (pixels_left <= LEFT_BITS'(1));
  end

  // Control outputs.
  always_comb begin
    out_free = !pixel_valid || !pixel_stall;
    cmd_pop  = 1'b0;
    if (state == BACK_RUN && cmd_valid) begin
      cmd_pop = cmd.is_start || !line_active || out_free;
    end
    emit     = cmd_pop && !cmd.is_start && line_active;
    load_div = cmd_pop && cmd.is_start && (cmd.step != '0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BACK_RUN:    if (load_div) state_next = BACK_DIVIDE;
      BACK_DIVIDE: if (div_last) state_next = BACK_RUN;
      default:     state_next = BACK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BACK_RUN;
      acc_x       <= '0;
      acc_y       <= '0;
      inc_x       <= '0;
      inc_y       <= '0;
      pixels_left <= '0;
      line_active <= 1'b0;
      div_cnt     <= '0;
      pixel_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (emit) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end

      if (cmd_pop && cmd.is_start) begin
        acc_x       <= {cmd.start_x, {FRAC_BITS{1'b0}}};
        acc_y       <= {cmd.start_y, {FRAC_BITS{1'b0}}};
        inc_x       <= '0;
        inc_y       <= '0;
        pixels_left <= {1'b0, cmd.step};
        line_active <= (cmd.step != '0);
        div_cnt     <= '0;
      end else if (state == BACK_DIVIDE) begin
        div_cnt <= div_cnt + 1'b1;
        if (div_last) begin
          inc_x <= neg_x ? -qx_ext : qx_ext;
          inc_y <= neg_y ? -qy_ext : qy_ext;
        end
      end else if (emit) begin
        acc_x <= acc_x + {{(ACC_BITS - INC_BITS){inc_x[INC_BITS-1]}}, inc_x};
        acc_y <= acc_y + {{(ACC_BITS - INC_BITS){inc_y[INC_BITS-1]}}, inc_y};
        if (last_one) begin
          pixels_left <= '0;
          line_active <= 1'b0;
        end else begin
          pixels_left <= pixels_left - 1'b1;
        end
      end
    end
  end

  // Divider datapath and output payload.
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_start) begin
      rem_x   <= {1'b0, cmd.mag_x};
      rem_y   <= {1'b0, cmd.mag_y};
      quo_x   <= '0;
      quo_y   <= '0;
      divisor <= cmd.step;
      neg_x   <= cmd.neg_x;
      neg_y   <= cmd.neg_y;
    end else if (state == BACK_DIVIDE) begin
      rem_x <= {sub_x[REM_BITS-2:0], 1'b0};
      rem_y <= {sub_y[REM_BITS-2:0], 1'b0};
      quo_x <= quo_x_next;
      quo_y <= quo_y_next;
    end
    if (emit) begin
      pixel.pixel_x    <= acc_x[ACC_BITS-1:FRAC_BITS];
      pixel.pixel_y    <= acc_y[ACC_BITS-1:FRAC_BITS];
      pixel.last_pixel <= last_one;
    end
  end

  `DDA_ASSERT(a_no_pop_in_divide, (state == BACK_DIVIDE) |-> !cmd_pop, "pop during divide")
  `DDA_ASSERT(a_last_ends_line, (emit && last_one) |=> !line_active, "line not closed")
  `DDA_ASSERT(a_idle_no_pixels, (!line_active && state == BACK_RUN) |-> (pixels_left == '0), "idle line has pixels left")
  `DDA_ASSERT(a_emit_into_room, emit |=> pixel_valid, "emitted pixel not presented")

endmodule
